// ----- rtl/phmb_pkg.sv -----
// ----------------------------------------------------------------------------
// phmb_pkg
// Shared types and constants of the per-pixel histogram median block.
// ----------------------------------------------------------------------------
package phmb_pkg;

   localparam int ROW_W = 5;
   localparam int COL_W = 5;
   localparam int PIX_W = ROW_W + COL_W;
   localparam int BIN_W = 8;
   localparam int CNT_W = 16;
   localparam int TOT_W = 24;
   localparam int MED_W = 9;
   localparam int MAX_DIM = 32;

   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_QUERY  = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   localparam logic [1:0] CSR_SAMPLE_INTERVAL = 2'd0;
   localparam logic [1:0] CSR_BIN_SIZE        = 2'd1;
   localparam logic [1:0] CSR_IMAGE_ROWS      = 2'd2;
   localparam logic [1:0] CSR_IMAGE_COLS      = 2'd3;

   // reciprocal scale: bin = (pixel * ceil(2^RECIP_SHIFT / bin_size)) >> RECIP_SHIFT
   localparam int RECIP_SHIFT = 17;
   localparam int DIV_W = 18;

   typedef struct packed {
      logic [1:0]       kind;
      logic [PIX_W-1:0] pidx;
      logic [BIN_W-1:0] bin;
   } qent_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- rtl/phmb_if.sv -----
// ----------------------------------------------------------------------------
// phmb_req_if / phmb_rsp_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface phmb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] pixel_value;
   logic [4:0] query_row;
   logic [4:0] query_col;
   modport source (output valid, req_type, pixel_value, query_row, query_col, input ready);
   modport sink   (input valid, req_type, pixel_value, query_row, query_col, output ready);
endinterface

interface phmb_rsp_if;
   logic        valid;
   logic        ready;
   logic [8:0]  median_half_bins;
   logic        pixel_empty;
   logic [23:0] sample_total;
   modport source (output valid, median_half_bins, pixel_empty, sample_total, input ready);
   modport sink   (input valid, median_half_bins, pixel_empty, sample_total, output ready);
endinterface

// ----- rtl/phmb_div.sv -----
// ----------------------------------------------------------------------------
// phmb_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module phmb_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [phmb_pkg::DIV_W-1:0]   dividend,
   input  logic [15:0]                  divisor,
   output logic [phmb_pkg::DIV_W-1:0]   quotient,
   output logic [15:0]                  remainder,
   output phmb_pkg::div_stat_type       stat
);
   logic [16:0]                r_ff, r_in;
   logic [phmb_pkg::DIV_W-1:0] q_ff, q_in;
   logic [15:0]                d_ff, d_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic [16:0]                rs;

   always_comb begin
      r_in    = r_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rs      = {r_ff[15:0], q_ff[phmb_pkg::DIV_W-1]};
      if (start) begin
         r_in    = '0;
         q_in    = dividend;
         d_in    = divisor;
         cnt_in  = 5'(phmb_pkg::DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rs >= {1'b0, d_ff}) begin
            r_in = rs - {1'b0, d_ff};
            q_in = {q_ff[phmb_pkg::DIV_W-2:0], 1'b1};
         end else begin
            r_in = rs;
            q_in = {q_ff[phmb_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      r_ff <= r_in;
      q_ff <= q_in;
      d_ff <= d_in;
   end

   assign quotient  = q_ff;
   assign remainder = r_ff[15:0];
   assign stat      = '{busy: busy_ff, done: done_ff};
endmodule

// ----- rtl/phmb_front.sv -----
// ----------------------------------------------------------------------------
// phmb_front
// Accepts requests, tracks raster position and frame phase, works out the
// bin of sampled pixels and hands work to the queue.
// ----------------------------------------------------------------------------
module phmb_front (
   input  logic               clock,
   input  logic               reset,
   phmb_req_if.sink           req,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output logic               push,
   output phmb_pkg::qent_type push_ent,
   input  logic               q_full
);
   logic [15:0] si_ff;
   logic [8:0]  bs_ff;
   logic [5:0]  rows_ff, cols_ff;
   logic [4:0]  row_ff, row_in, col_ff, col_in;
   logic [15:0] frame_ff, frame_in, rem_ff, rem_in;
   logic [phmb_pkg::DIV_W-1:0] recip_ff;
   logic        rem_go_ff, recip_go_ff;

   logic [15:0] si_eff;
   logic [8:0]  bs_eff;
   logic [5:0]  rows_eff, cols_eff;
   logic        busy, accept;
   logic [25:0] prod;
   logic [5:0]  col_nxt, row_nxt;
   logic [16:0] rem_nxt;

   logic [phmb_pkg::DIV_W-1:0] rem_q, recip_q;
   logic [15:0] rem_r, recip_r;
   phmb_pkg::div_stat_type rem_st, recip_st;

   assign si_eff   = (si_ff == 16'd0) ? 16'd1 : si_ff;
   assign bs_eff   = (bs_ff == 9'd0) ? 9'd1 : bs_ff;
   assign rows_eff = (rows_ff == 6'd0) ? 6'd1 :
                     (rows_ff > 6'(phmb_pkg::MAX_DIM)) ? 6'(phmb_pkg::MAX_DIM) : rows_ff;
   assign cols_eff = (cols_ff == 6'd0) ? 6'd1 :
                     (cols_ff > 6'(phmb_pkg::MAX_DIM)) ? 6'(phmb_pkg::MAX_DIM) : cols_ff;

   phmb_div u_rem_div (
      .clock, .reset,
      .start     (rem_go_ff),
      .dividend  ({2'b00, frame_ff}),
      .divisor   (si_eff),
      .quotient  (rem_q),
      .remainder (rem_r),
      .stat      (rem_st)
   );

   phmb_div u_recip_div (
      .clock, .reset,
      .start     (recip_go_ff),
      .dividend  (18'(1 << phmb_pkg::RECIP_SHIFT) + 18'(bs_eff) - 18'd1),
      .divisor   ({7'd0, bs_eff}),
      .quotient  (recip_q),
      .remainder (recip_r),
      .stat      (recip_st)
   );

   assign busy = rem_go_ff | recip_go_ff | rem_st.busy | rem_st.done |
                 recip_st.busy | recip_st.done;
   assign req.ready = !busy && !q_full;
   assign accept    = req.valid && req.ready;

   assign prod = req.pixel_value * recip_ff;

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      frame_in = frame_ff;
      rem_in   = rem_ff;
      col_nxt  = {1'b0, col_ff} + 6'd1;
      row_nxt  = {1'b0, row_ff} + 6'd1;
      rem_nxt  = {1'b0, rem_ff} + 17'd1;
      push     = 1'b0;
      push_ent.kind = req.req_type;
      push_ent.pidx = {req.query_row, req.query_col};
      push_ent.bin  = prod[phmb_pkg::RECIP_SHIFT+phmb_pkg::BIN_W-1:phmb_pkg::RECIP_SHIFT];
      if (rem_st.done) rem_in = rem_r;
      if (accept) begin
         case (req.req_type)
            phmb_pkg::REQ_SAMPLE: begin
               push_ent.pidx = {row_ff, col_ff};
               push = (rem_ff == 16'd0);
               if (col_nxt >= cols_eff) begin
                  col_in = '0;
                  if (row_nxt >= rows_eff) begin
                     row_in   = '0;
                     frame_in = frame_ff + 16'd1;
                     if (frame_ff == 16'hFFFF || rem_nxt == {1'b0, si_eff})
                        rem_in = '0;
                     else
                        rem_in = rem_nxt[15:0];
                  end else begin
                     row_in = row_nxt[4:0];
                  end
               end else begin
                  col_in = col_nxt[4:0];
               end
            end
            phmb_pkg::REQ_QUERY: push = 1'b1;
            phmb_pkg::REQ_CLEAR: push = 1'b1;
            default: push = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         si_ff       <= 16'd50;
         bs_ff       <= 9'd1;
         rows_ff     <= 6'd32;
         cols_ff     <= 6'd32;
         row_ff      <= '0;
         col_ff      <= '0;
         frame_ff    <= '0;
         rem_ff      <= '0;
         recip_ff    <= 18'(1 << phmb_pkg::RECIP_SHIFT);
         rem_go_ff   <= 1'b0;
         recip_go_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         frame_ff    <= frame_in;
         rem_ff      <= rem_in;
         rem_go_ff   <= csr_we && (csr_index == phmb_pkg::CSR_SAMPLE_INTERVAL);
         recip_go_ff <= csr_we && (csr_index == phmb_pkg::CSR_BIN_SIZE);
         if (recip_st.done) recip_ff <= recip_q;
         if (csr_we) begin
            case (csr_index)
               phmb_pkg::CSR_SAMPLE_INTERVAL: si_ff <= csr_wdata;
               phmb_pkg::CSR_BIN_SIZE:        bs_ff <= csr_wdata[8:0];
               phmb_pkg::CSR_IMAGE_ROWS:      rows_ff <= csr_wdata[5:0];
               phmb_pkg::CSR_IMAGE_COLS:      cols_ff <= csr_wdata[5:0];
               default: ;
            endcase
         end
      end
   end

   // quotient of the phase divider and remainder of the reciprocal are not needed
   logic unused_bits;
   assign unused_bits = ^{rem_q, recip_r};
endmodule

// ----- rtl/phmb_queue.sv -----
// ----------------------------------------------------------------------------
// phmb_queue
// Four-entry register FIFO between front and back.
// ----------------------------------------------------------------------------
module phmb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  phmb_pkg::qent_type push_ent,
   output logic               full,
   input  logic               pop,
   output logic               avail,
   output phmb_pkg::qent_type head
);
   phmb_pkg::qent_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign full  = (cnt_ff == 3'd4);
   assign avail = (cnt_ff != 3'd0);
   assign head  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 2'd1;
         if (pop)  rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'b00, push} - {2'b00, pop};
      end
      if (push) mem_ff[wp_ff] <= push_ent;
   end
endmodule

// ----- rtl/phmb_back.sv -----
// ----------------------------------------------------------------------------
// phmb_back
// Histogram store: sample increments, median walk and clearing sweep.
// ----------------------------------------------------------------------------
module phmb_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_avail,
   input  phmb_pkg::qent_type q_head,
   output logic               pop,
   phmb_rsp_if.source         rsp
);
   localparam int ADDR_W = phmb_pkg::PIX_W + phmb_pkg::BIN_W;

   localparam logic [2:0] ST_CLR   = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SWR   = 3'd2;
   localparam logic [2:0] ST_QTOT  = 3'd3;
   localparam logic [2:0] ST_QWALK = 3'd4;

   logic [phmb_pkg::CNT_W-1:0] bin_mem [2**ADDR_W];
   logic [phmb_pkg::TOT_W-1:0] tot_mem [2**phmb_pkg::PIX_W];

   logic [2:0]                 st_ff, st_in;
   logic [ADDR_W-1:0]          clr_ff, clr_in;
   phmb_pkg::qent_type         ent_ff, ent_in;
   logic [phmb_pkg::BIN_W-1:0] b_ff, b_in;
   logic [24:0]                sum_ff, sum_in;
   logic [phmb_pkg::TOT_W-1:0] tot_ff, tot_in;

   logic [ADDR_W-1:0]          bin_ra;
   logic [phmb_pkg::PIX_W-1:0] tot_ra;
   logic [phmb_pkg::CNT_W-1:0] bin_q_ff;
   logic [phmb_pkg::TOT_W-1:0] tot_q_ff;

   logic                       bin_we, tot_we;
   logic [ADDR_W-1:0]          bin_wa;
   logic [phmb_pkg::PIX_W-1:0] tot_wa;
   logic [phmb_pkg::CNT_W-1:0] bin_wd;
   logic [phmb_pkg::TOT_W-1:0] tot_wd;

   logic       rv_ff, rv_in;
   logic [8:0] med_ff, med_in;
   logic       emp_ff, emp_in;
   logic [23:0] rtot_ff, rtot_in;
   logic [24:0] acc;
   logic        hit;

   assign acc = sum_ff + {9'd0, bin_q_ff};
   assign hit = acc > {2'd0, tot_ff[23:1]};

   always_comb begin
      st_in  = st_ff;
      clr_in = clr_ff;
      ent_in = ent_ff;
      b_in   = b_ff;
      sum_in = sum_ff;
      tot_in = tot_ff;
      pop    = 1'b0;
      bin_ra = {ent_ff.pidx, ent_ff.bin};
      tot_ra = ent_ff.pidx;
      bin_we = 1'b0;
      tot_we = 1'b0;
      bin_wa = {ent_ff.pidx, ent_ff.bin};
      tot_wa = ent_ff.pidx;
      bin_wd = (bin_q_ff == 16'hFFFF) ? bin_q_ff : bin_q_ff + 16'd1;
      tot_wd = (tot_q_ff == 24'hFFFFFF) ? tot_q_ff : tot_q_ff + 24'd1;
      rv_in   = rv_ff & ~rsp.ready;
      med_in  = med_ff;
      emp_in  = emp_ff;
      rtot_in = rtot_ff;
      case (st_ff)
         ST_CLR: begin
            bin_we = 1'b1;
            bin_wa = clr_ff;
            bin_wd = '0;
            tot_we = (clr_ff[ADDR_W-1:phmb_pkg::PIX_W] == '0);
            tot_wa = clr_ff[phmb_pkg::PIX_W-1:0];
            tot_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            bin_ra = {q_head.pidx, q_head.bin};
            tot_ra = q_head.pidx;
            // a query only starts once the response slot is free
            if (q_avail && (q_head.kind != phmb_pkg::REQ_QUERY || !rv_ff)) begin
               pop    = 1'b1;
               ent_in = q_head;
               case (q_head.kind)
                  phmb_pkg::REQ_SAMPLE: st_in = ST_SWR;
                  phmb_pkg::REQ_QUERY:  st_in = ST_QTOT;
                  phmb_pkg::REQ_CLEAR: begin
                     st_in  = ST_CLR;
                     clr_in = '0;
                  end
                  default: st_in = ST_IDLE;
               endcase
            end
         end
         ST_SWR: begin
            bin_we = 1'b1;
            tot_we = 1'b1;
            st_in  = ST_IDLE;
         end
         ST_QTOT: begin
            bin_ra = {ent_ff.pidx, 8'd0};
            if (tot_q_ff == '0) begin
               rv_in   = 1'b1;
               med_in  = '0;
               emp_in  = 1'b1;
               rtot_in = '0;
               st_in   = ST_IDLE;
            end else begin
               tot_in = tot_q_ff;
               sum_in = '0;
               b_in   = '0;
               st_in  = ST_QWALK;
            end
         end
         ST_QWALK: begin
            bin_ra = {ent_ff.pidx, b_ff + 8'd1};
            sum_in = acc;
            if (hit || b_ff == 8'hFF) begin
               rv_in   = 1'b1;
               emp_in  = 1'b0;
               rtot_in = tot_ff;
               // half-bin step for an even total split across a thin bin
               if (tot_ff[0] || bin_q_ff > 16'd1 || b_ff == 8'd0)
                  med_in = {b_ff, 1'b0};
               else
                  med_in = {b_ff, 1'b0} - 9'd1;
               st_in = ST_IDLE;
            end else begin
               b_in = b_ff + 8'd1;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_CLR;
         clr_ff <= '0;
         rv_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
         rv_ff  <= rv_in;
      end
      ent_ff  <= ent_in;
      b_ff    <= b_in;
      sum_ff  <= sum_in;
      tot_ff  <= tot_in;
      med_ff  <= med_in;
      emp_ff  <= emp_in;
      rtot_ff <= rtot_in;
   end

   always_ff @(posedge clock) begin
      if (bin_we) bin_mem[bin_wa] <= bin_wd;
      bin_q_ff <= bin_mem[bin_ra];
   end

   always_ff @(posedge clock) begin
      if (tot_we) tot_mem[tot_wa] <= tot_wd;
      tot_q_ff <= tot_mem[tot_ra];
   end

   assign rsp.valid            = rv_ff;
   assign rsp.median_half_bins = med_ff;
   assign rsp.pixel_empty      = emp_ff;
   assign rsp.sample_total     = rtot_ff;
endmodule

// ----- rtl/pixel_histogram_median_background.sv -----
// ----------------------------------------------------------------------------
// pixel_histogram_median_background
// Per-pixel background histogram with median query.
//
//   channel  dir  handshake         contents
//   req      in   valid/ready       req_type, pixel_value, query_row/col
//   rsp      out  valid/ready       median_half_bins, pixel_empty, sample_total
//   csr      in   write enable      csr_index, csr_wdata (16 bits)
//
// The front takes a request per cycle while req.ready is high; the back
// does a sample as a read-modify-write on one memory port, walks a query
// one bin read a cycle and sweeps the whole store on a clear, and also
// after reset before the first request is carried out. A full queue or a
// write to sample_interval or bin_size holds req.ready low, the latter
// while the serial divider reworks the frame phase or the bin reciprocal.
// ----------------------------------------------------------------------------
module pixel_histogram_median_background (
   input  logic        clock,
   input  logic        reset,
   phmb_req_if.sink    req,
   phmb_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   logic               push, q_full, q_pop, q_avail;
   phmb_pkg::qent_type push_ent, q_head;

   phmb_front u_front (
      .clock, .reset,
      .req,
      .csr_we, .csr_index, .csr_wdata,
      .push, .push_ent, .q_full
   );

   phmb_queue u_queue (
      .clock, .reset,
      .push, .push_ent,
      .full  (q_full),
      .pop   (q_pop),
      .avail (q_avail),
      .head  (q_head)
   );

   phmb_back u_back (
      .clock, .reset,
      .q_avail,
      .q_head,
      .pop (q_pop),
      .rsp
   );
endmodule

// ----- sim/phmb_checker.sv -----
// ----------------------------------------------------------------------------
// phmb_checker
// Watches the request, response and register ports of the histogram block.
// Keeps its own copy of the histogram store, counters and registers, works
// out the median answer for every accepted query and compares each
// accepted response, field by field, against the oldest outstanding answer.
// ----------------------------------------------------------------------------
module phmb_checker (
   input  logic        clock,
   input  logic        reset,
   phmb_req_if         req,
   phmb_rsp_if         rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatches,
   output int          pending
);
   localparam int NBINS = 256;

   typedef struct packed {
      logic [phmb_pkg::MED_W-1:0] med;
      logic                       empty;
      logic [phmb_pkg::TOT_W-1:0] total;
   } median_ans_type;

   logic [phmb_pkg::CNT_W-1:0] bin_count [phmb_pkg::MAX_DIM*phmb_pkg::MAX_DIM*NBINS];
   logic [phmb_pkg::TOT_W-1:0] pix_total [phmb_pkg::MAX_DIM*phmb_pkg::MAX_DIM];
   logic [15:0]      frame_no;
   int unsigned      row_pos, col_pos;
   logic [15:0]      interval_reg;
   logic [8:0]       bin_size_reg;
   logic [5:0]       rows_reg, cols_reg;
   median_ans_type   answers [$];
   int               errs;

   function automatic int unsigned at_least_one(int unsigned v);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic int unsigned clamp_dim(int unsigned v);
      int unsigned w;
      w = at_least_one(v);
      return (w > phmb_pkg::MAX_DIM) ? phmb_pkg::MAX_DIM : w;
   endfunction

   task automatic clear_store();
      foreach (bin_count[i]) bin_count[i] = '0;
      foreach (pix_total[i]) pix_total[i] = '0;
   endtask

   task automatic add_pixel(input logic [7:0] pix);
      int unsigned pidx, bin, cidx;
      if (frame_no % at_least_one(interval_reg) == 0) begin
         pidx = row_pos * phmb_pkg::MAX_DIM + col_pos;
         bin  = pix / at_least_one(bin_size_reg);
         if (bin >= NBINS) bin = NBINS - 1;
         cidx = pidx * NBINS + bin;
         if (bin_count[cidx] != '1) bin_count[cidx] = bin_count[cidx] + 1'b1;
         if (pix_total[pidx] != '1) pix_total[pidx] = pix_total[pidx] + 1'b1;
      end
      col_pos++;
      if (col_pos >= clamp_dim(cols_reg)) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= clamp_dim(rows_reg)) begin
            row_pos  = 0;
            frame_no = frame_no + 16'd1;
         end
      end
   endtask

   function automatic median_ans_type median_of(input logic [4:0] qr,
                                                input logic [4:0] qc);
      median_ans_type a;
      int unsigned pidx, tot, half, sum, b, v, m;
      a = '{med: '0, empty: 1'b1, total: '0};
      pidx = qr * phmb_pkg::MAX_DIM + qc;
      tot  = pix_total[pidx];
      if (tot == 0) return a;
      half = tot / 2;
      sum  = 0;
      v    = 0;
      for (b = 0; b < NBINS; b++) begin
         v   = bin_count[pidx * NBINS + b];
         sum += v;
         if (sum > half) break;
      end
      if (b >= NBINS) b = NBINS - 1;
      // even total with a thin crossing bin sits half a bin lower
      if (tot[0] || v > 1) m = 2 * b;
      else                 m = (b == 0) ? 0 : 2 * b - 1;
      a.med   = m[phmb_pkg::MED_W-1:0];
      a.empty = 1'b0;
      a.total = tot[phmb_pkg::TOT_W-1:0];
      return a;
   endfunction

   always @(posedge clock) begin
      median_ans_type got, want;
      if (reset) begin
         clear_store();
         frame_no     = '0;
         row_pos      = 0;
         col_pos      = 0;
         interval_reg = 16'd50;
         bin_size_reg = 9'd1;
         rows_reg     = 6'd32;
         cols_reg     = 6'd32;
         answers.delete();
         errs = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               phmb_pkg::CSR_SAMPLE_INTERVAL: interval_reg = csr_wdata;
               phmb_pkg::CSR_BIN_SIZE:        bin_size_reg = csr_wdata[8:0];
               phmb_pkg::CSR_IMAGE_ROWS:      rows_reg     = csr_wdata[5:0];
               phmb_pkg::CSR_IMAGE_COLS:      cols_reg     = csr_wdata[5:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            case (req.req_type)
               phmb_pkg::REQ_SAMPLE: add_pixel(req.pixel_value);
               phmb_pkg::REQ_QUERY:
                  answers.push_back(median_of(req.query_row, req.query_col));
               phmb_pkg::REQ_CLEAR:  clear_store();
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            got = '{med: rsp.median_half_bins, empty: rsp.pixel_empty,
                    total: rsp.sample_total};
            if (answers.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("ERROR: unexpected response med=%0d empty=%0b total=%0d",
                           got.med, got.empty, got.total);
            end else begin
               want = answers.pop_front();
               if (got != want) begin
                  errs++;
                  if (errs <= 10)
                     $display({"ERROR: median exp med=%0d empty=%0b total=%0d, ",
                               "got med=%0d empty=%0b total=%0d"},
                              want.med, want.empty, want.total,
                              got.med, got.empty, got.total);
               end
            end
         end
      end
      mismatches <= errs;
      pending    <= answers.size();
   end

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the per-pixel histogram median block: directed
// samples, queries and a clear, then random phases under several register
// settings, random stalls on both channels bar the last; phmb_checker checks.
// ----------------------------------------------------------------------------
module tb;
   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 1000000;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_REQS = 170;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   int          mismatches, pending;
   int          idle_cycles;
   bit          quiet;

   phmb_req_if req_ch ();
   phmb_rsp_if rsp_ch ();

   pixel_histogram_median_background uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   phmb_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // response-side back-pressure
   initial begin
      rsp_ch.ready <= 1'b1;
      forever begin
         repeat ($urandom_range(1, 30)) @(posedge clock);
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_req(input logic [1:0] kind, input logic [7:0] pix,
                           input logic [4:0] qr, input logic [4:0] qc);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= kind;
      req_ch.pixel_value <= pix;
      req_ch.query_row   <= qr;
      req_ch.query_col   <= qc;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // block must have drained before the registers move
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_regs(input logic [15:0] si, input logic [15:0] bs,
                           input logic [15:0] nr, input logic [15:0] nc);
      write_csr(phmb_pkg::CSR_SAMPLE_INTERVAL, si);
      write_csr(phmb_pkg::CSR_BIN_SIZE, bs);
      write_csr(phmb_pkg::CSR_IMAGE_ROWS, nr);
      write_csr(phmb_pkg::CSR_IMAGE_COLS, nc);
   endtask

   initial begin
      logic [15:0] si_set [NUM_PHASES];
      logic [15:0] bs_set [NUM_PHASES];
      logic [15:0] nr_set [NUM_PHASES];
      logic [15:0] nc_set [NUM_PHASES];
      logic [7:0]  first_frame [6];
      int          eff_r, eff_c, pick;

      si_set = '{16'd1, 16'd2, 16'd0, 16'd65535, 16'd3, 16'd1, 16'd1, 16'hFFFF};
      bs_set = '{16'd1, 16'd256, 16'd0, 16'h01FF, 16'd37, 16'd16, 16'd2, 16'd1};
      nr_set = '{16'd1, 16'd4, 16'd0, 16'd63, 16'd32, 16'd2, 16'd3, 16'd2};
      nc_set = '{16'd1, 16'd3, 16'd63, 16'd0, 16'd32, 16'd5, 16'd2, 16'd4};
      si_set[6] = 16'($urandom_range(1, 6));
      bs_set[6] = 16'($urandom_range(1, 256));
      first_frame = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd7};

      quiet              = 1'b0;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= phmb_pkg::CSR_SAMPLE_INTERVAL;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.req_type    <= phmb_pkg::REQ_SAMPLE;
      req_ch.pixel_value <= '0;
      req_ch.query_row   <= '0;
      req_ch.query_col   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: two 2x3 frames, queries, an ignored request, clear and query
      set_regs(16'd1, 16'd1, 16'd2, 16'd3);
      foreach (first_frame[i])
         send_req(phmb_pkg::REQ_SAMPLE, first_frame[i], 5'd0, 5'd0);
      send_req(phmb_pkg::REQ_SAMPLE, 8'd255, 5'd0, 5'd0);
      send_req(phmb_pkg::REQ_SAMPLE, 8'd255, 5'd0, 5'd0);
      send_req(phmb_pkg::REQ_SAMPLE, 8'd0,   5'd0, 5'd0);
      send_req(phmb_pkg::REQ_SAMPLE, 8'd1,   5'd0, 5'd0);
      send_req(phmb_pkg::REQ_SAMPLE, 8'd200, 5'd0, 5'd0);
      send_req(phmb_pkg::REQ_SAMPLE, 8'd7,   5'd0, 5'd0);
      send_req(phmb_pkg::REQ_QUERY, 8'd0, 5'd0, 5'd0);
      send_req(phmb_pkg::REQ_QUERY, 8'd0, 5'd0, 5'd1);
      send_req(phmb_pkg::REQ_QUERY, 8'd0, 5'd0, 5'd2);
      send_req(phmb_pkg::REQ_QUERY, 8'd0, 5'd1, 5'd0);
      send_req(phmb_pkg::REQ_QUERY, 8'd0, 5'd1, 5'd2);
      send_req(phmb_pkg::REQ_QUERY, 8'hFF, 5'd31, 5'd31);
      send_req(REQ_UNUSED, 8'hFF, 5'd31, 5'd31);
      send_req(phmb_pkg::REQ_CLEAR, 8'd0, 5'd0, 5'd0);
      send_req(phmb_pkg::REQ_QUERY, 8'd0, 5'd0, 5'd0);
      settle();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         set_regs(si_set[ph], bs_set[ph], nr_set[ph], nc_set[ph]);
         quiet = (ph == NUM_PHASES - 1);
         eff_r = (nr_set[ph][5:0] == 6'd0) ? 1 :
                 ((nr_set[ph][5:0] > 6'd32) ? 32 : int'(nr_set[ph][5:0]));
         eff_c = (nc_set[ph][5:0] == 6'd0) ? 1 :
                 ((nc_set[ph][5:0] > 6'd32) ? 32 : int'(nc_set[ph][5:0]));
         for (int n = 0; n < PHASE_REQS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
               send_req(phmb_pkg::REQ_SAMPLE, 8'($urandom_range(0, 255)),
                        5'($urandom), 5'($urandom));
            else if (pick < 98 || n == PHASE_REQS - 1) begin
               if ($urandom_range(0, 3) != 0)
                  send_req(phmb_pkg::REQ_QUERY, 8'($urandom),
                           5'($urandom_range(0, eff_r - 1)),
                           5'($urandom_range(0, eff_c - 1)));
               else
                  send_req(phmb_pkg::REQ_QUERY, 8'($urandom),
                           5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            end else
               send_req(REQ_UNUSED, 8'($urandom), 5'($urandom), 5'($urandom));
         end
         settle();
      end

      if (mismatches == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
